[src/dsba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsba_pkg
// Shared types, constants and zone helpers for the sector bitmap allocator.
// ----------------------------------------------------------------------------
package dsba_pkg;

  localparam int TRK_W = 7;
  localparam int SEC_W = 5;
  localparam int SUM_W = 11;
  localparam int MAP_W = 21;   // widest track map any zone can have

  localparam int SIDE_TRACKS = 35;
  localparam logic [TRK_W-1:0] CATALOG_TRACK = 7'd18;
  localparam logic [TRK_W-1:0] MAP1_TRACK    = 7'd53;
  localparam logic [MAP_W-1:0] DIR_MASK      = 21'h03;
  localparam logic [MAP_W-1:0] MAP1_MASK     = 21'h01;

  localparam logic [SEC_W-1:0] ZONE0_SECTORS = 5'd21;
  localparam logic [SEC_W-1:0] ZONE1_SECTORS = 5'd19;
  localparam logic [SEC_W-1:0] ZONE2_SECTORS = 5'd18;
  localparam logic [SEC_W-1:0] ZONE3_SECTORS = 5'd17;

  localparam logic [2:0] OP_QUERY  = 3'd0;
  localparam logic [2:0] OP_ALLOC  = 3'd1;
  localparam logic [2:0] OP_FREE   = 3'd2;
  localparam logic [2:0] OP_NEAR   = 3'd3;
  localparam logic [2:0] OP_FORMAT = 3'd4;

  // Sectors on a track, capped at ms; 0 for tracks off both sides.
  function automatic logic [SEC_W-1:0] zone_sectors(input logic [TRK_W-1:0] t,
                                                     input logic [SEC_W-1:0] ms);
    logic [TRK_W-1:0] r;
    logic [SEC_W-1:0] n;
    r = (t > TRK_W'(SIDE_TRACKS)) ? t - TRK_W'(SIDE_TRACKS) : t;
    n = '0;
    if (r >= 7'd1 && r <= 7'd17) n = ZONE0_SECTORS;
    else if (r >= 7'd18 && r <= 7'd24) n = ZONE1_SECTORS;
    else if (r >= 7'd25 && r <= 7'd30) n = ZONE2_SECTORS;
    else if (r >= 7'd31 && r <= 7'd35) n = ZONE3_SECTORS;
    if (n > ms) n = ms;
    return n;
  endfunction

  // Freshly formatted map of one track.
  function automatic logic [MAP_W-1:0] fmt_bits(input logic [TRK_W-1:0] t,
                                                input logic [SEC_W-1:0] ms);
    logic [MAP_W-1:0] b;
    b = (MAP_W'(1) << zone_sectors(t, ms)) - MAP_W'(1);
    if (t == CATALOG_TRACK) b = b & ~DIR_MASK;
    if (t == MAP1_TRACK) b = b & ~MAP1_MASK;
    return b;
  endfunction

  // Free total of a formatted disk, evaluated at elaboration.
  function automatic int fmt_sum(input int tc, input int ms);
    int s;
    logic [MAP_W-1:0] b;
    s = 0;
    for (int t = 1; t <= tc; t++) begin
      b = fmt_bits(TRK_W'(t), SEC_W'(ms));
      for (int i = 0; i < MAP_W; i++) s = s + int'(b[i]);
    end
    return s;
  endfunction

endpackage

[src/dsba_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsba_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 70
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/disk_sector_bitmap_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_sector_bitmap_allocator
// Free-sector bitmap of a two-sided zoned disk: query, allocate, free,
// allocate-near search and format, one request at a time.
// ----------------------------------------------------------------------------
// Allocate-near checks one candidate track a cycle from the bitmap RAM read
// port. A new request is taken while a result still waits on rsp_stall.
// Reset: synchronous; the map reads as formatted at once (per-track valid
// bits), no clearing pass.
module disk_sector_bitmap_allocator
  import dsba_pkg::*;
#(
  parameter int TRACK_COUNT = 70,
  parameter int MAX_SECTORS = 21
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  logic [2:0]       operation,
  input  logic [TRK_W-1:0] track,
  input  logic [SEC_W-1:0] sector,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output logic             ok,
  output logic             bad_address,
  output logic [TRK_W-1:0] found_track,
  output logic [SEC_W-1:0] found_sector,
  output logic [SUM_W-1:0] free_total
);

  localparam int AW = $clog2(TRACK_COUNT);
  localparam logic [SUM_W-1:0] FMT_SUM = SUM_W'(fmt_sum(TRACK_COUNT, MAX_SECTORS));
  localparam logic [SEC_W-1:0] MS = SEC_W'(MAX_SECTORS);
  localparam logic [TRK_W:0]   TC_W = (TRK_W + 1)'(TRACK_COUNT);

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_SEARCH, S_FINISH} state_t;

  state_t                 state;
  logic [2:0]             op_q;
  logic [SEC_W-1:0]       sec_q;
  logic [TRK_W-1:0]       near_q;
  logic [TRK_W-1:0]       span;
  logic                   dir;
  logic                   gen_done;
  logic                   pend;
  logic [TRK_W-1:0]       last_trk;
  logic [TRACK_COUNT-1:0] valid_bits;
  logic [SUM_W-1:0]       free_sum;
  logic                   r_ok;
  logic                   r_bad;
  logic [TRK_W-1:0]       r_ft;
  logic [SEC_W-1:0]       r_fs;

  logic                   req_fire;
  logic                   addr_bad;
  logic [TRK_W-1:0]       near_in;
  logic [TRK_W:0]         cand;
  logic                   cand_ok;
  logic [MAX_SECTORS-1:0] ram_rdata;
  logic [MAX_SECTORS-1:0] cur_bits;
  logic [MAX_SECTORS-1:0] shifted;
  logic                   sel_bit;
  logic [SEC_W-1:0]       low_idx;
  logic                   found;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [MAX_SECTORS-1:0] ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [AW-1:0]          last_idx;
  logic                   out_free;

  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  assign addr_bad = (track == '0) || ({1'b0, track} > TC_W) ||
                    (sector >= zone_sectors(track, MS));
  assign near_in  = (track == '0) ? CATALOG_TRACK : track;

  // Next candidate of the outward search: above at even steps, below at odd.
  always_comb begin
    if (dir) begin
      cand    = {1'b0, near_q - span};
      cand_ok = (span < near_q);
    end else begin
      cand    = {1'b0, near_q} + {1'b0, span};
      cand_ok = 1'b1;
    end
    cand_ok = cand_ok && (cand != '0) && (cand <= TC_W) &&
              (cand[TRK_W-1:0] != CATALOG_TRACK) && (cand[TRK_W-1:0] != MAP1_TRACK);
  end

  // A track never written since format reads as its formatted pattern.
  assign last_idx = AW'(last_trk - TRK_W'(1));
  assign cur_bits = valid_bits[last_idx] ? ram_rdata
                                         : MAX_SECTORS'(fmt_bits(last_trk, MS));
  assign shifted  = cur_bits >> sec_q;
  assign sel_bit  = shifted[0];
  assign found    = pend && (cur_bits != '0);

  always_comb begin
    low_idx = '0;
    for (int i = MAX_SECTORS - 1; i >= 0; i--) begin
      if (cur_bits[i]) low_idx = SEC_W'(i);
    end
  end

  always_comb begin
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = last_idx;
    ram_wdata = cur_bits;
    unique case (state)
      S_IDLE: begin
        ram_raddr = AW'(track - TRK_W'(1));
      end
      S_CHECK: begin
        if (op_q == OP_ALLOC) begin
          ram_we    = sel_bit;
          ram_wdata = cur_bits & ~(MAX_SECTORS'(1) << sec_q);
        end else if (op_q == OP_FREE) begin
          ram_we    = !sel_bit;
          ram_wdata = cur_bits | (MAX_SECTORS'(1) << sec_q);
        end
      end
      S_SEARCH: begin
        ram_raddr = AW'(cand[TRK_W-1:0] - TRK_W'(1));
        ram_we    = found;
        ram_wdata = cur_bits & (cur_bits - MAX_SECTORS'(1));  // drop lowest free
      end
      S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  dsba_ram #(
    .WIDTH(MAX_SECTORS),
    .DEPTH(TRACK_COUNT)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid_bits <= '0;
      free_sum   <= FMT_SUM;
      rsp_valid  <= 1'b0;
      pend       <= 1'b0;
      gen_done   <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_FINISH) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            op_q     <= operation;
            sec_q    <= sector;
            last_trk <= track;
            r_ok     <= 1'b0;
            r_bad    <= 1'b0;
            r_ft     <= '0;
            r_fs     <= '0;
            priority case (1'b1)
              (operation == OP_QUERY) || (operation == OP_ALLOC) ||
              (operation == OP_FREE): begin
                if (addr_bad) begin
                  r_bad <= 1'b1;
                  state <= S_FINISH;
                end else begin
                  state <= S_CHECK;
                end
              end
              operation == OP_NEAR: begin
                if ({1'b0, near_in} > TC_W) begin
                  r_bad <= 1'b1;
                  state <= S_FINISH;
                end else begin
                  near_q   <= near_in;
                  span     <= '0;
                  dir      <= 1'b0;
                  gen_done <= 1'b0;
                  pend     <= 1'b0;
                  state    <= S_SEARCH;
                end
              end
              operation == OP_FORMAT: begin
                valid_bits <= '0;
                free_sum   <= FMT_SUM;
                r_ok       <= 1'b1;
                state      <= S_FINISH;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_CHECK: begin
          if (op_q == OP_QUERY) begin
            r_ok <= sel_bit;
          end else if (ram_we) begin
            r_ok                 <= 1'b1;
            valid_bits[last_idx] <= 1'b1;
            free_sum <= (op_q == OP_ALLOC) ? free_sum - SUM_W'(1)
                                           : free_sum + SUM_W'(1);
          end
          state <= S_FINISH;
        end
        S_SEARCH: begin
          if (found) begin
            valid_bits[last_idx] <= 1'b1;
            free_sum <= free_sum - SUM_W'(1);
            r_ok     <= 1'b1;
            r_ft     <= last_trk;
            r_fs     <= low_idx;
            pend     <= 1'b0;
            state    <= S_FINISH;
          end else if (gen_done) begin
            pend  <= 1'b0;
            state <= S_FINISH;
          end else begin
            // read for this candidate lands next cycle
            pend     <= cand_ok;
            last_trk <= cand[TRK_W-1:0];
            if (!dir) begin
              dir <= 1'b1;
            end else begin
              dir <= 1'b0;
              if (span == TRK_W'(TRACK_COUNT - 1)) gen_done <= 1'b1;
              else span <= span + TRK_W'(1);
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            rsp_valid    <= 1'b1;
            ok           <= r_ok;
            bad_address  <= r_bad;
            found_track  <= r_ft;
            found_sector <= r_fs;
            free_total   <= free_sum;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[test/dsba_alloc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsba_alloc_checker
// Watches the request and response channels of the sector bitmap allocator.
// It keeps its own copy of the free map, predicts every response and compares
// each field in order of arrival.
// ----------------------------------------------------------------------------
module dsba_alloc_checker
  import dsba_pkg::*;
#(
  parameter int NUM_TRACKS = 70,
  parameter int SECTOR_CAP = 21
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_stall,
  input  logic [2:0]       operation,
  input  logic [TRK_W-1:0] track,
  input  logic [SEC_W-1:0] sector,
  input  logic             rsp_valid,
  input  logic             rsp_stall,
  input  logic             ok,
  input  logic             bad_address,
  input  logic [TRK_W-1:0] found_track,
  input  logic [SEC_W-1:0] found_sector,
  input  logic [SUM_W-1:0] free_total,
  output int               mismatch_count,
  output int               outstanding
);

  typedef struct packed {
    logic             ok;
    logic             bad;
    logic [TRK_W-1:0] trk;
    logic [SEC_W-1:0] sec;
    logic [SUM_W-1:0] total;
  } alloc_result_t;

  logic [MAP_W-1:0] sector_map [1:NUM_TRACKS];
  logic [SEC_W-1:0] map_count  [1:NUM_TRACKS];
  logic [SUM_W-1:0] free_count;
  alloc_result_t    expected_results [$];

  function automatic int sectors_on_track(input int t);
    int rel;
    int n;
    rel = (t > SIDE_TRACKS) ? t - SIDE_TRACKS : t;
    if (rel < 1 || rel > SIDE_TRACKS) n = 0;
    else if (rel <= 17) n = 21;
    else if (rel <= 24) n = 19;
    else if (rel <= 30) n = 18;
    else n = 17;
    return (n > SECTOR_CAP) ? SECTOR_CAP : n;
  endfunction

  function automatic void format_disk();
    logic [MAP_W-1:0] bits;
    free_count = '0;
    for (int t = 1; t <= NUM_TRACKS; t++) begin
      bits = (MAP_W'(1) << sectors_on_track(t)) - MAP_W'(1);
      if (t == CATALOG_TRACK) bits &= ~DIR_MASK;
      if (t == MAP1_TRACK) bits &= ~MAP1_MASK;
      sector_map[t] = bits;
      map_count[t]  = SEC_W'($countones(bits));
      free_count    = free_count + SUM_W'(map_count[t]);
    end
  endfunction

  function automatic void claim(input int t, input int s);
    sector_map[t][s] = 1'b0;
    map_count[t]     = map_count[t] - 1'b1;
    free_count       = free_count - 1'b1;
  endfunction

  function automatic void release_sector(input int t, input int s);
    sector_map[t][s] = 1'b1;
    map_count[t]     = map_count[t] + 1'b1;
    free_count       = free_count + 1'b1;
  endfunction

  function automatic alloc_result_t predict_result(input logic [2:0] op,
                                                   input logic [TRK_W-1:0] trk,
                                                   input logic [SEC_W-1:0] sec);
    alloc_result_t r;
    int  origin;
    int  cand;
    int  lowest;
    bit  done;
    bit  is_free;
    r    = '0;
    done = 1'b0;
    if (op == OP_QUERY || op == OP_ALLOC || op == OP_FREE) begin
      if (trk < 1 || trk > NUM_TRACKS || sec >= sectors_on_track(trk)) begin
        r.bad = 1'b1;
      end else begin
        is_free = sector_map[trk][sec];
        if (op == OP_QUERY) begin
          r.ok = is_free;
        end else if (op == OP_ALLOC) begin
          if (is_free) begin
            claim(trk, sec);
            r.ok = 1'b1;
          end
        end else if (!is_free) begin
          release_sector(trk, sec);
          r.ok = 1'b1;
        end
      end
    end else if (op == OP_NEAR) begin
      origin = (trk == 0) ? int'(CATALOG_TRACK) : int'(trk);
      if (origin > NUM_TRACKS) begin
        r.bad = 1'b1;
      end else begin
        // outward search: track above first, then the one below
        for (int span = 0; span < NUM_TRACKS && !done; span++) begin
          for (int side = 0; side < 2 && !done; side++) begin
            cand = (side == 0) ? origin + span : origin - span;
            if (cand >= 1 && cand <= NUM_TRACKS && cand != CATALOG_TRACK &&
                cand != MAP1_TRACK && sector_map[cand] != '0) begin
              lowest = 0;
              while (!sector_map[cand][lowest]) lowest++;
              claim(cand, lowest);
              r.ok  = 1'b1;
              r.trk = TRK_W'(cand);
              r.sec = SEC_W'(lowest);
              done  = 1'b1;
            end
          end
        end
      end
    end else if (op == OP_FORMAT) begin
      format_disk();
      r.ok = 1'b1;
    end
    r.total = free_count;
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    alloc_result_t want;
    if (rst) begin
      format_disk();
      expected_results.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: response beat with none expected, expected none, %s %0d %0d %0d/%0d %0d",
                   $time, "actual", ok, bad_address, found_track, found_sector,
                   free_total);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("ok", want.ok, ok);
          compare_field("bad_address", want.bad, bad_address);
          compare_field("found_track", want.trk, found_track);
          compare_field("found_sector", want.sec, found_sector);
          compare_field("free_total", want.total, free_total);
        end
      end
      if (req_valid && !req_stall)
        expected_results = {expected_results, predict_result(operation, track, sector)};
    end
    outstanding <= expected_results.size();
  end

endmodule

[test/disk_sector_bitmap_allocator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_sector_bitmap_allocator_tb
// Drives directed and random request beats into the allocator with random
// gaps and response stalls, fills the disk once by near allocation, and
// takes the verdict from the checker beside the block.
// ----------------------------------------------------------------------------
module disk_sector_bitmap_allocator_tb;
  import dsba_pkg::*;

  localparam int QUIET_LIMIT = 5000;

  logic             clk;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  logic [2:0]       operation = '0;
  logic [TRK_W-1:0] track = '0;
  logic [SEC_W-1:0] sector = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  logic             ok;
  logic             bad_address;
  logic [TRK_W-1:0] found_track;
  logic [SEC_W-1:0] found_sector;
  logic [SUM_W-1:0] free_total;

  int mismatch_count;
  int outstanding;
  int quiet_cycles = 0;
  bit idling = 1'b1;

  disk_sector_bitmap_allocator dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .operation(operation), .track(track), .sector(sector),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .ok(ok), .bad_address(bad_address), .found_track(found_track),
    .found_sector(found_sector), .free_total(free_total)
  );

  dsba_alloc_checker u_chk (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .operation(operation), .track(track), .sector(sector),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .ok(ok), .bad_address(bad_address), .found_track(found_track),
    .found_sector(found_sector), .free_total(free_total),
    .mismatch_count(mismatch_count), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) rsp_stall <= 1'b0;
    else rsp_stall <= idling && ($urandom_range(0, 99) < 25);
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (!rst) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("disk_sector_bitmap_allocator_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [2:0] op, input logic [TRK_W-1:0] trk,
                              input logic [SEC_W-1:0] sec);
    while (idling && $urandom_range(0, 99) < 25) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    track     <= trk;
    sector    <= sec;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // sender holds off until every outstanding response is back
  task automatic drain_responses();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [TRK_W-1:0] near_origin();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return TRK_W'($urandom_range(71, 127));
    if (pick < 20) return '0;
    return TRK_W'($urandom_range(1, 70));
  endfunction

  task automatic send_mixed();
    logic [2:0]       op;
    logic [TRK_W-1:0] trk;
    logic [SEC_W-1:0] sec;
    int               pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      op  = 3'($urandom_range(0, 7));
      trk = TRK_W'($urandom_range(0, 127));
      sec = SEC_W'($urandom_range(0, 31));
    end else begin
      // half of the non-random beats hit tracks 15-21 or 50-56 so alloc and free collide
      if ($urandom_range(0, 1)) trk = TRK_W'($urandom_range(1, 70));
      else if ($urandom_range(0, 1)) trk = TRK_W'($urandom_range(15, 21));
      else trk = TRK_W'($urandom_range(50, 56));
      sec = $urandom_range(0, 1) ? SEC_W'($urandom_range(0, 3)) : SEC_W'($urandom_range(0, 20));
      pick = $urandom_range(0, 99);
      if (pick < 22) op = OP_QUERY;
      else if (pick < 48) op = OP_ALLOC;
      else if (pick < 72) op = OP_FREE;
      else if (pick < 98) begin
        op  = OP_NEAR;
        trk = near_origin();
        sec = SEC_W'($urandom_range(0, 31));
      end else op = OP_FORMAT;
    end
    send_request(op, trk, sec);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: zone edges, reserved sectors, bad addresses, every op
    send_request(OP_QUERY, 7'd1, 5'd0);
    send_request(OP_QUERY, 7'd18, 5'd0);
    send_request(OP_QUERY, 7'd53, 5'd0);
    send_request(OP_QUERY, 7'd0, 5'd0);
    send_request(OP_QUERY, 7'd71, 5'd0);
    send_request(OP_QUERY, 7'd127, 5'd31);
    send_request(OP_QUERY, 7'd17, 5'd21);
    send_request(OP_QUERY, 7'd24, 5'd19);
    send_request(OP_QUERY, 7'd30, 5'd18);
    send_request(OP_QUERY, 7'd70, 5'd17);
    send_request(OP_ALLOC, 7'd1, 5'd20);
    send_request(OP_ALLOC, 7'd1, 5'd20);
    send_request(OP_FREE, 7'd1, 5'd20);
    send_request(OP_FREE, 7'd1, 5'd20);
    send_request(OP_FREE, 7'd18, 5'd1);
    send_request(OP_NEAR, 7'd0, 5'd31);
    send_request(OP_NEAR, 7'd18, 5'd0);
    send_request(OP_NEAR, 7'd53, 5'd0);
    send_request(OP_NEAR, 7'd70, 5'd0);
    send_request(OP_NEAR, 7'd71, 5'd0);
    send_request(OP_NEAR, 7'd127, 5'd31);
    send_request(3'd5, 7'd127, 5'd31);
    send_request(3'd6, 7'd1, 5'd0);
    send_request(3'd7, 7'd35, 5'd16);
    send_request(OP_FORMAT, 7'd127, 5'd31);
    drain_responses();

    for (int i = 0; i < 120; i++) begin
      if (i == 60) drain_responses();
      send_mixed();
    end

    // fill the disk through near allocation until it runs out
    drain_responses();
    send_request(OP_FORMAT, 7'd0, 5'd0);
    for (int i = 0; i < 1370; i++) begin
      idling = !(i >= 300 && i < 700);
      send_request(OP_NEAR, TRK_W'($urandom_range(0, 70)), SEC_W'($urandom_range(0, 31)));
    end
    idling = 1'b1;
    for (int i = 0; i < 30; i++) begin
      if ($urandom_range(0, 1))
        send_request(OP_FREE, TRK_W'($urandom_range(1, 70)), SEC_W'($urandom_range(0, 20)));
      else
        send_request(OP_NEAR, TRK_W'($urandom_range(0, 70)), SEC_W'($urandom_range(0, 31)));
    end

    drain_responses();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("disk_sector_bitmap_allocator_tb: done, clean");
    end else begin
      $display("disk_sector_bitmap_allocator_tb: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
src/dsba_pkg.sv
src/dsba_ram.sv
src/disk_sector_bitmap_allocator.sv
test/dsba_alloc_checker.sv
test/disk_sector_bitmap_allocator_tb.sv
